>>> sv/cwcs_pkg.sv
`default_nettype none
package cwcs_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_EVAL   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_WINDOW_VALUE = 2'd0,
    CFG_WINDOW_PCT   = 2'd1,
    CFG_BIN_MAP      = 2'd2,
    CFG_BIN_COUNT    = 2'd3
  } cfg_idx_t;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_BAD_POS   = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  localparam logic [7:0] SYM_A = 8'h41;
  localparam logic [7:0] SYM_C = 8'h43;
  localparam logic [7:0] SYM_G = 8'h47;
  localparam logic [7:0] SYM_T = 8'h54;

  localparam logic [2:0] IGNORED_CODE = 3'd4;
  localparam int         NUM_CODES    = 4;
  localparam int         Q_SHIFT      = 12;
  localparam logic [6:0] PCT_MAX      = 7'd100;

  // divide by PCT_MAX as multiply by ceil(2^37 / 100), then shift right by 37
  localparam logic [31:0] PCT_RECIP       = 32'h51EB_851F;
  localparam int          PCT_RECIP_SHIFT = 37;

  typedef enum logic {
    MDU_MUL,
    MDU_DIV
  } mdu_op_t;

  typedef struct packed {
    logic    go;
    mdu_op_t op;
  } mdu_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WMUL,
    S_WDIV,
    S_WALK,
    S_DRAIN,
    S_SUMS,
    S_SSMUL,
    S_BIN,
    S_P1,
    S_P2,
    S_SQ,
    S_DEN,
    S_DIV
  } fsm_t;

endpackage
`default_nettype wire

>>> sv/circular_window_chi_square_skew.sv
`default_nettype none
// Channel   Handshake              Payload
// request   start / busy           in_operation, in_symbol, in_position
// result    out_valid (1 cycle)    out_chi_square, out_skew_negative,
//                                  out_degrees_of_freedom, out_status
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Clear, append, the unused opcode and rejected evaluates are answered directly; the result strobes next cycle.
// Evaluate walks 2*W store reads (W = window width, one store read per cycle), then
// a sums multiply and, per used bin, four multiplies and one divide in the shared
// multiply/divide unit, plus two further multiplies for a percentage width.
// Synchronous reset clears length and counts and restores the configuration defaults; the store is not cleared.
// Results are not stalled; busy stays high until the result strobe.
module circular_window_chi_square_skew #(
  parameter int MAX_LENGTH = 262144,
  parameter int MAX_BINS   = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_operation,
  input  wire logic [7:0]        in_symbol,
  input  wire logic [17:0]       in_position,
  output logic                   out_valid,
  output logic [31:0]            out_chi_square,
  output logic                   out_skew_negative,
  output logic signed [2:0]      out_degrees_of_freedom,
  output logic [1:0]             out_status,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [18:0]       cfg_data
);
  import cwcs_pkg::*;

  localparam int LW   = $clog2(MAX_LENGTH + 1);
  localparam int IW   = $clog2(MAX_LENGTH);
  localparam int CW   = (LW > 19) ? LW : 19;
  localparam int PW   = 2 * CW;
  localparam int AW   = PW + 1;
  localparam int BW   = PW;
  localparam int NW   = 2 * PW + Q_SHIFT;
  localparam int DW   = 3 * CW + 1;
  localparam int XW   = (LW > 18) ? LW : 18;

  fsm_t state_r, state_nxt;

  logic [18:0] wv_r;
  logic        wpct_r;
  logic [7:0]  map_r;
  logic [2:0]  bc_r;

  logic [LW-1:0] len_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] pos_r;
  logic [CW-1:0] width_r;
  logic [CW-1:0] k_r;
  logic          side_r;
  logic          rd_v_r;
  logic [2:0]    rd_data_r;
  logic [CW-1:0] rc_r [NUM_CODES];
  logic [CW-1:0] lc_r [NUM_CODES];
  logic [2:0]    j_r;
  logic [2:0]    df_r;
  logic [31:0]   chi_r;
  logic [PW-1:0] p1_r;
  logic [PW-1:0] d_r;
  logic [2*PW-1:0] sq_r;
  logic [PW-1:0] ss_r;
  logic [DW-1:0] den_r;
  logic          issued_r;

  logic        out_valid_r;
  logic [31:0] out_chi_r;
  logic        out_skew_r;
  logic [2:0]  out_df_r;
  logic [1:0]  out_stat_r;

  logic [2:0] store_mem [MAX_LENGTH];

  logic           accept;
  logic           pos_ok;
  logic           full;
  logic [2:0]     sym_code;
  logic [2:0]     nb;
  logic [CW+1:0]  s1_sum, s2_sum;
  logic [CW-1:0]  s1, s2;
  logic [2:0]     empty_n;
  logic [CW-1:0]  b1, b2;
  logic [PW-1:0]  p2;
  logic [LW-1:0]  len_m1;
  logic [IW-1:0]  idx_fwd, idx_back, left_start;
  logic           mem_re;
  logic [6:0]     pct;
  logic           arith_st;
  logic [32:0]    chi_sum;

  mdu_req_t          mdu_req;
  logic [AW-1:0]     mul_a;
  logic [BW-1:0]     mul_b;
  logic [NW-1:0]     div_num;
  logic [DW-1:0]     div_den;
  logic              mdu_done;
  logic [AW+BW-1:0]  mdu_prod;
  logic [31:0]       mdu_quot;

  cwcs_mdu #(.AW(AW), .BW(BW), .NW(NW), .DW(DW)) u_mdu (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mdu_req),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .div_num (div_num),
    .div_den (div_den),
    .done    (mdu_done),
    .prod    (mdu_prod),
    .quot    (mdu_quot)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign pos_ok    = (XW'(in_position) < XW'(len_r));
  assign full      = ((LW+1)'(len_r) >= (LW+1)'(MAX_LENGTH));
  assign pct       = (wv_r > 19'(PCT_MAX)) ? PCT_MAX : wv_r[6:0];
  assign len_m1    = len_r - 1'b1;
  assign left_start = (pos_r == '0) ? len_m1[IW-1:0] : pos_r - 1'b1;
  assign idx_fwd   = ((IW+1)'(idx_r) + 1'b1 >= (IW+1)'(len_r)) ? '0 : idx_r + 1'b1;
  assign idx_back  = (idx_r == '0) ? len_m1[IW-1:0] : idx_r - 1'b1;
  assign mem_re    = (state_r == S_WALK) && (k_r != '0);
  assign b1        = rc_r[j_r[1:0]];
  assign b2        = lc_r[j_r[1:0]];
  assign p2        = mdu_prod[PW-1:0];
  assign chi_sum   = {1'b0, chi_r} + {1'b0, mdu_quot};

  always_comb begin
    case (in_symbol)
      SYM_A:   sym_code = {1'b0, map_r[1:0]};
      SYM_C:   sym_code = {1'b0, map_r[3:2]};
      SYM_G:   sym_code = {1'b0, map_r[5:4]};
      SYM_T:   sym_code = {1'b0, map_r[7:6]};
      default: sym_code = IGNORED_CODE;
    endcase
  end

  always_comb begin
    if (bc_r < 3'd2) begin
      nb = 3'd2;
    end else if (bc_r > 3'(MAX_BINS)) begin
      nb = 3'(MAX_BINS);
    end else begin
      nb = bc_r;
    end
  end

  always_comb begin
    s1_sum  = '0;
    s2_sum  = '0;
    empty_n = '0;
    for (int j = 0; j < NUM_CODES; j++) begin
      if (3'(j) < nb) begin
        s1_sum = s1_sum + (CW+2)'(rc_r[j]);
        s2_sum = s2_sum + (CW+2)'(lc_r[j]);
        if (rc_r[j] == '0 && lc_r[j] == '0) begin
          empty_n = empty_n + 1'b1;
        end
      end
    end
    s1 = s1_sum[CW-1:0];
    s2 = s2_sum[CW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && op_t'(in_operation) == OP_EVAL && pos_ok) begin
          state_nxt = wpct_r ? S_WMUL : S_WALK;
        end
      end
      S_WMUL:  if (mdu_done) state_nxt = S_WDIV;
      S_WDIV:  if (mdu_done) state_nxt = S_WALK;
      S_WALK:  if (k_r == '0 && side_r) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_SUMS;
      S_SUMS:  state_nxt = (s1 == '0 || s2 == '0) ? S_IDLE : S_SSMUL;
      S_SSMUL: if (mdu_done) state_nxt = S_BIN;
      S_BIN: begin
        if (j_r >= nb) begin
          state_nxt = S_IDLE;
        end else if (b1 != '0 || b2 != '0) begin
          state_nxt = S_P1;
        end
      end
      S_P1:    if (mdu_done) state_nxt = S_P2;
      S_P2:    if (mdu_done) state_nxt = S_SQ;
      S_SQ:    if (mdu_done) state_nxt = S_DEN;
      S_DEN:   if (mdu_done) state_nxt = S_DIV;
      S_DIV:   if (mdu_done) state_nxt = S_BIN;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    arith_st = 1'b0;
    mdu_req  = '{go: 1'b0, op: MDU_MUL};
    mul_a    = '0;
    mul_b    = '0;
    div_num  = '0;
    div_den  = '0;
    case (state_r)
      S_WMUL: begin
        arith_st = 1'b1;
        mul_a    = AW'(len_r);
        mul_b    = BW'(pct);
      end
      S_WDIV: begin
        arith_st = 1'b1;
        mul_a    = mdu_prod[AW-1:0];
        mul_b    = BW'(PCT_RECIP);
      end
      S_SSMUL: begin
        arith_st = 1'b1;
        mul_a    = AW'(s1);
        mul_b    = BW'(s2);
      end
      S_P1: begin
        arith_st = 1'b1;
        mul_a    = AW'(b1);
        mul_b    = BW'(s2);
      end
      S_P2: begin
        arith_st = 1'b1;
        mul_a    = AW'(b2);
        mul_b    = BW'(s1);
      end
      S_SQ: begin
        arith_st = 1'b1;
        mul_a    = AW'(d_r);
        mul_b    = d_r;
      end
      S_DEN: begin
        arith_st = 1'b1;
        mul_a    = AW'(ss_r);
        mul_b    = BW'((CW+1)'(b1) + (CW+1)'(b2));
      end
      S_DIV: begin
        arith_st   = 1'b1;
        mdu_req.op = MDU_DIV;
        div_num    = {sq_r, Q_SHIFT'(0)};
        div_den    = den_r;
      end
      default: begin
      end
    endcase
    mdu_req.go = arith_st && !issued_r;
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= store_mem[idx_r];
    end
    if (accept && op_t'(in_operation) == OP_APPEND && !full) begin
      store_mem[len_r[IW-1:0]] <= sym_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wv_r        <= 19'd25;
      wpct_r      <= 1'b1;
      map_r       <= 8'd228;
      bc_r        <= 3'd4;
      len_r       <= '0;
      issued_r    <= 1'b0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      side_r      <= 1'b0;
      j_r         <= '0;
      for (int j = 0; j < NUM_CODES; j++) begin
        rc_r[j] <= '0;
        lc_r[j] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      rd_v_r      <= mem_re;

      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WINDOW_VALUE: wv_r   <= cfg_data;
          CFG_WINDOW_PCT:   wpct_r <= cfg_data[0];
          CFG_BIN_MAP:      map_r  <= cfg_data[7:0];
          CFG_BIN_COUNT:    bc_r   <= cfg_data[2:0];
          default: begin
          end
        endcase
      end

      if (mdu_req.go) begin
        issued_r <= 1'b1;
      end else if (mdu_done) begin
        issued_r <= 1'b0;
      end

      if (rd_v_r && !rd_data_r[2]) begin
        if (side_r) begin
          lc_r[rd_data_r[1:0]] <= lc_r[rd_data_r[1:0]] + 1'b1;
        end else begin
          rc_r[rd_data_r[1:0]] <= rc_r[rd_data_r[1:0]] + 1'b1;
        end
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_chi_r  <= '0;
            out_skew_r <= 1'b0;
            out_df_r   <= '0;
            out_stat_r <= STAT_OK;
            case (op_t'(in_operation))
              OP_CLEAR: begin
                len_r       <= '0;
                out_valid_r <= 1'b1;
              end
              OP_APPEND: begin
                out_valid_r <= 1'b1;
                if (full) begin
                  out_stat_r <= STAT_FULL;
                end else begin
                  len_r <= len_r + 1'b1;
                end
              end
              OP_EVAL: begin
                if (!pos_ok) begin
                  out_valid_r <= 1'b1;
                  out_stat_r  <= STAT_BAD_POS;
                end else begin
                  pos_r  <= IW'(in_position);
                  idx_r  <= IW'(in_position);
                  side_r <= 1'b0;
                  width_r <= CW'(wv_r);
                  k_r     <= wpct_r ? '0 : CW'(wv_r);
                  for (int j = 0; j < NUM_CODES; j++) begin
                    rc_r[j] <= '0;
                    lc_r[j] <= '0;
                  end
                end
              end
              default: out_valid_r <= 1'b1;
            endcase
          end
        end
        S_WDIV: begin
          if (mdu_done) begin
            width_r <= mdu_prod[PCT_RECIP_SHIFT +: CW];
            k_r     <= mdu_prod[PCT_RECIP_SHIFT +: CW];
          end
        end
        S_WALK: begin
          if (k_r != '0) begin
            k_r   <= k_r - 1'b1;
            idx_r <= side_r ? idx_back : idx_fwd;
          end else if (!side_r) begin
            side_r <= 1'b1;
            k_r    <= width_r;
            idx_r  <= left_start;
          end
        end
        S_SUMS: begin
          if (s1 == '0 || s2 == '0) begin
            out_valid_r <= 1'b1;
            out_chi_r   <= '0;
            out_skew_r  <= 1'b0;
            out_df_r    <= '0;
            out_stat_r  <= STAT_EMPTY;
          end else begin
            df_r  <= nb - 1'b1 - empty_n;
            chi_r <= '0;
            j_r   <= '0;
          end
        end
        S_SSMUL: if (mdu_done) ss_r <= mdu_prod[PW-1:0];
        S_BIN: begin
          if (j_r >= nb) begin
            out_valid_r <= 1'b1;
            out_chi_r   <= chi_r;
            out_skew_r  <= (nb == 3'd2) && (rc_r[0] < lc_r[0]);
            out_df_r    <= df_r;
            out_stat_r  <= STAT_OK;
          end else if (b1 == '0 && b2 == '0) begin
            j_r <= j_r + 1'b1;
          end
        end
        S_P1: if (mdu_done) p1_r <= mdu_prod[PW-1:0];
        S_P2: if (mdu_done) d_r <= (p1_r >= p2) ? p1_r - p2 : p2 - p1_r;
        S_SQ: if (mdu_done) sq_r <= mdu_prod[2*PW-1:0];
        S_DEN: if (mdu_done) den_r <= mdu_prod[DW-1:0];
        S_DIV: begin
          if (mdu_done) begin
            chi_r <= chi_sum[32] ? '1 : chi_sum[31:0];
            j_r   <= j_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid              = out_valid_r;
  assign out_chi_square         = out_chi_r;
  assign out_skew_negative      = out_skew_r;
  assign out_degrees_of_freedom = out_df_r;
  assign out_status             = out_stat_r;

endmodule
`default_nettype wire

>>> sv/cwcs_mdu.sv
`default_nettype none
module cwcs_mdu #(
  parameter int AW = 39,
  parameter int BW = 38,
  parameter int NW = 88,
  parameter int DW = 58
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cwcs_pkg::mdu_req_t req,
  input  wire logic [AW-1:0]      mul_a,
  input  wire logic [BW-1:0]      mul_b,
  input  wire logic [NW-1:0]      div_num,
  input  wire logic [DW-1:0]      div_den,
  output logic                    done,
  output logic [AW+BW-1:0]        prod,
  output logic [31:0]             quot
);
  import cwcs_pkg::*;

  localparam int MAXI = (NW > BW) ? NW : BW;
  localparam int CNTW = $clog2(MAXI + 1);

  logic            busy_r;
  mdu_op_t         op_r;
  logic [CNTW-1:0] cnt_r;
  logic [AW+BW-1:0] prod_r;
  logic [AW-1:0]   mcd_r;
  logic [BW-1:0]   mpl_r;
  logic [DW-1:0]   rem_r;
  logic [NW-1:0]   dvd_r;
  logic [DW-1:0]   dvs_r;
  logic [31:0]     q_r;
  logic            ovf_r;
  logic            done_r;

  logic [DW:0]     trial;
  logic            qbit;
  logic [DW:0]     diff;

  assign trial = {rem_r, dvd_r[NW-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= MDU_MUL;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        prod_r <= '0;
        mcd_r  <= mul_a;
        mpl_r  <= mul_b;
        rem_r  <= '0;
        dvd_r  <= div_num;
        dvs_r  <= div_den;
        q_r    <= '0;
        ovf_r  <= 1'b0;
        cnt_r  <= (req.op == MDU_MUL) ? CNTW'(BW) : CNTW'(NW);
      end else if (busy_r) begin
        case (op_r)
          MDU_MUL: begin
            prod_r <= (prod_r << 1) + (mpl_r[BW-1] ? (AW+BW)'(mcd_r) : '0);
            mpl_r  <= mpl_r << 1;
          end
          MDU_DIV: begin
            rem_r <= qbit ? diff[DW-1:0] : trial[DW-1:0];
            dvd_r <= dvd_r << 1;
            q_r   <= {q_r[30:0], qbit};
            ovf_r <= ovf_r | q_r[31];
          end
          default: begin
          end
        endcase
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = prod_r;
  assign quot = ovf_r ? '1 : q_r;

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none
module tb_top;
  import cwcs_pkg::*;

  localparam int STORE_DEPTH = 262144;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    bit [31:0]       chi;
    bit              skew;
    bit signed [2:0] dof;
    bit [1:0]        status;
  } skew_result_t;

  class skew_scoreboard;
    bit [2:0]     store [STORE_DEPTH];
    int unsigned  seq_len;
    bit [18:0]    win_value;
    bit           win_pct;
    bit [7:0]     bin_map;
    bit [2:0]     bins_reg;
    skew_result_t expected_q[$];
    int unsigned  accepted, evals_ok, evals_empty, full_hits, mismatches;

    function new();
      seq_len = 0;
      win_value = 25;
      win_pct = 1;
      bin_map = 228;
      bins_reg = 4;
    endfunction

    function void set_reg(cfg_idx_t idx, bit [18:0] data);
      case (idx)
        CFG_WINDOW_VALUE: win_value = data;
        CFG_WINDOW_PCT:   win_pct = data[0];
        CFG_BIN_MAP:      bin_map = data[7:0];
        CFG_BIN_COUNT:    bins_reg = data[2:0];
      endcase
    endfunction

    function skew_result_t evaluate(int unsigned pos);
      skew_result_t r;
      int unsigned nb, width, pct, idx, empties;
      longint unsigned rc[4], lc[4];
      longint unsigned s1, s2, b1, b2, p1, p2, d;
      bit [127:0] num, den, q;
      bit [32:0] chi;
      r = '{0, 0, 0, 0};
      nb = (bins_reg < 2) ? 2 : (bins_reg > 4) ? 4 : bins_reg;
      if (pos >= seq_len) begin
        r.status = STAT_BAD_POS;
        return r;
      end
      if (win_pct) begin
        pct = (win_value > PCT_MAX) ? PCT_MAX : win_value;
        width = (longint'(seq_len) * pct) / 100;
      end else begin
        width = win_value;
      end
      for (int j = 0; j < 4; j++) begin
        rc[j] = 0;
        lc[j] = 0;
      end
      idx = pos;
      for (int unsigned k = 0; k < width; k++) begin
        if (store[idx] < IGNORED_CODE) rc[store[idx]]++;
        idx = (idx + 1 >= seq_len) ? 0 : idx + 1;
      end
      idx = (pos == 0) ? seq_len - 1 : pos - 1;
      for (int unsigned k = 0; k < width; k++) begin
        if (store[idx] < IGNORED_CODE) lc[store[idx]]++;
        idx = (idx == 0) ? seq_len - 1 : idx - 1;
      end
      s1 = 0;
      s2 = 0;
      for (int j = 0; j < nb; j++) begin
        s1 += rc[j];
        s2 += lc[j];
      end
      if (s1 == 0 || s2 == 0) begin
        r.status = STAT_EMPTY;
        evals_empty++;
        return r;
      end
      chi = 0;
      empties = 0;
      for (int j = 0; j < nb; j++) begin
        b1 = rc[j];
        b2 = lc[j];
        if (b1 == 0 && b2 == 0) begin
          empties++;
          continue;
        end
        p1 = b1 * s2;
        p2 = b2 * s1;
        d = (p1 >= p2) ? p1 - p2 : p2 - p1;
        num = (128'(d) * 128'(d)) << Q_SHIFT;
        den = 128'(b1 + b2) * 128'(s1) * 128'(s2);
        q = num / den;
        if (q > 128'hFFFF_FFFF) q = 128'hFFFF_FFFF;
        chi = chi + q[32:0];
        if (chi > 33'hFFFF_FFFF) chi = 33'hFFFF_FFFF;
      end
      r.chi = chi[31:0];
      r.skew = (nb == 2 && rc[0] < lc[0]);
      r.dof = 3'(nb - 1 - empties);
      evals_ok++;
      return r;
    endfunction

    function void note_request(bit [1:0] op, bit [7:0] sym, bit [17:0] pos);
      skew_result_t r;
      int nuc;
      r = '{0, 0, 0, 0};
      accepted++;
      if (op == OP_CLEAR) begin
        seq_len = 0;
      end else if (op == OP_APPEND) begin
        if (seq_len >= STORE_DEPTH) begin
          r.status = STAT_FULL;
          full_hits++;
        end else begin
          case (sym)
            SYM_A:   nuc = 0;
            SYM_C:   nuc = 1;
            SYM_G:   nuc = 2;
            SYM_T:   nuc = 3;
            default: nuc = -1;
          endcase
          store[seq_len] = (nuc < 0) ? IGNORED_CODE : 3'((bin_map >> (2 * nuc)) & 3);
          seq_len++;
        end
      end else if (op == OP_EVAL) begin
        r = evaluate(pos);
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(bit [31:0] chi, bit skew, bit signed [2:0] dof, bit [1:0] st);
      skew_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: chi=%h status=%0d", chi, st);
        return;
      end
      e = expected_q.pop_front();
      if (e.chi !== chi || e.skew !== skew || e.dof !== dof || e.status !== st) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected chi=%h skew=%0d dof=%0d status=%0d, got chi=%h skew=%0d dof=%0d status=%0d",
                   e.chi, e.skew, e.dof, e.status, chi, skew, dof, st);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              start = 0;
  logic              busy;
  logic [1:0]        in_operation = 0;
  logic [7:0]        in_symbol = 0;
  logic [17:0]       in_position = 0;
  logic              out_valid;
  logic [31:0]       out_chi_square;
  logic              out_skew_negative;
  logic signed [2:0] out_degrees_of_freedom;
  logic [1:0]        out_status;
  logic              cfg_valid = 0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = 0;
  logic [18:0]       cfg_data = 0;

  skew_scoreboard sb = new();
  int unsigned    cycles = 0;
  int unsigned    idle_pct = 0;

  circular_window_chi_square_skew DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_symbol(in_symbol), .in_position(in_position),
    .out_valid(out_valid), .out_chi_square(out_chi_square),
    .out_skew_negative(out_skew_negative), .out_degrees_of_freedom(out_degrees_of_freedom),
    .out_status(out_status), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_request(in_operation, in_symbol, in_position);
    if (rst_n && out_valid)
      sb.check_result(out_chi_square, out_skew_negative, out_degrees_of_freedom, out_status);
  end

  task automatic send(bit [1:0] op, bit [7:0] sym, bit [17:0] pos);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1;
    in_operation <= op;
    in_symbol <= sym;
    in_position <= pos;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, bit [18:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic bit [7:0] pick_symbol();
    bit [7:0] nucs [4] = '{SYM_A, SYM_C, SYM_G, SYM_T};
    if ($urandom_range(99) < 85) return nucs[$urandom_range(3)];
    return 8'($urandom);
  endfunction

  task automatic random_set();
    int unsigned n;
    send(OP_CLEAR, 8'($urandom), 18'($urandom));
    n = $urandom_range(1, 40);
    for (int i = 0; i < n; i++) send(OP_APPEND, pick_symbol(), 18'($urandom));
    repeat ($urandom_range(2, 8)) begin
      if ($urandom_range(99) < 85) send(OP_EVAL, 8'($urandom), 18'($urandom_range(n - 1)));
      else if ($urandom_range(1)) send(OP_EVAL, 8'($urandom), 18'($urandom));
      else send(2'd3, 8'($urandom), 18'($urandom));
    end
  endtask

  initial begin
    int phase;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send(OP_EVAL, 8'h00, 18'd0);
    send(OP_APPEND, SYM_A, 18'h3FFFF);
    send(OP_APPEND, SYM_C, 18'd0);
    send(OP_APPEND, SYM_G, 18'd0);
    send(OP_APPEND, SYM_T, 18'd0);
    send(OP_APPEND, 8'h61, 18'd0);
    send(OP_APPEND, 8'h00, 18'd0);
    send(OP_APPEND, 8'hFF, 18'd0);
    send(OP_APPEND, SYM_A, 18'd0);
    send(OP_EVAL, 8'hFF, 18'd0);
    send(OP_EVAL, 8'h00, 18'd7);
    send(OP_EVAL, 8'h00, 18'd8);
    send(OP_EVAL, 8'h00, 18'h3FFFF);
    send(2'd3, 8'hAA, 18'h15555);
    drain();
    write_reg(CFG_WINDOW_VALUE, 19'd262144);
    send(OP_EVAL, 8'h00, 18'd3);
    drain();
    write_reg(CFG_WINDOW_PCT, 19'd0);
    write_reg(CFG_WINDOW_VALUE, 19'd1);
    write_reg(CFG_BIN_COUNT, 19'd2);
    write_reg(CFG_BIN_MAP, 19'h1B);
    send(OP_EVAL, 8'h00, 18'd0);
    send(OP_EVAL, 8'h00, 18'd2);
    drain();
    write_reg(CFG_WINDOW_VALUE, 19'd20);
    write_reg(CFG_BIN_COUNT, 19'd7);
    send(OP_EVAL, 8'h00, 18'd4);
    drain();
    write_reg(CFG_BIN_COUNT, 19'd0);
    write_reg(CFG_BIN_MAP, 19'd0);
    send(OP_EVAL, 8'h00, 18'd5);
    send(OP_CLEAR, 8'h00, 18'd0);
    send(OP_EVAL, 8'h00, 18'd0);
    drain();

    phase = 0;
    while (sb.accepted < 520) begin
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 74;
        2: idle_pct = 0;
        default: idle_pct = 28;
      endcase
      if ($urandom_range(1)) begin
        write_reg(CFG_WINDOW_PCT, 19'd1);
        write_reg(CFG_WINDOW_VALUE, 19'($urandom_range(1, 130)));
      end else begin
        write_reg(CFG_WINDOW_PCT, 19'd0);
        write_reg(CFG_WINDOW_VALUE, 19'($urandom_range(1, 48)));
      end
      write_reg(CFG_BIN_MAP, 19'($urandom_range(255)));
      write_reg(CFG_BIN_COUNT, 19'($urandom_range(2, 4)));
      repeat (3) random_set();
      drain();
      phase++;
    end

    idle_pct = 0;
    write_reg(CFG_WINDOW_PCT, 19'd0);
    write_reg(CFG_WINDOW_VALUE, 19'd3);
    write_reg(CFG_BIN_MAP, 19'd228);
    write_reg(CFG_BIN_COUNT, 19'd4);
    send(OP_CLEAR, 8'h00, 18'd0);
    for (int i = 0; i < 12; i++) send(OP_APPEND, pick_symbol(), 18'd0);
    send(OP_EVAL, 8'h00, 18'd11);
    send(OP_EVAL, 8'h00, 18'd12);
    send(OP_EVAL, 8'h00, 18'd0);
    send(OP_CLEAR, 8'h00, 18'd0);
    send(OP_APPEND, SYM_T, 18'd0);
    send(OP_EVAL, 8'h00, 18'd0);
    drain();
    repeat (20) @(posedge clk);

    $display("Covered %0d requests: %0d evaluates with a statistic, %0d empty windows, %0d full-store appends.",
             sb.accepted, sb.evals_ok, sb.evals_empty, sb.full_hits);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> circular_window_chi_square_skew.f
sv/cwcs_pkg.sv
sv/cwcs_mdu.sv
sv/circular_window_chi_square_skew.sv
bench/tb_top.sv
